@@ design/pcgn_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcgn_pkg
// Shared types, codes and sizes of the periodic cell grid neighbour table.
// ---------------------------------------------------------------------------
package pcgn_pkg;

   // defaults of the top level parameters
   localparam int MAX_CELLS_PER_AXIS_DEF = 32;
   localparam int WINDOW_REACH_DEF       = 2;
   localparam int ID_BITS_DEF            = 16;
   localparam int COORD_BITS_DEF         = 32;

   // fixed field widths
   localparam int EXT_BITS      = 31;
   localparam int CELL_REG_BITS = 6;
   localparam int CSR_IDX_BITS  = 3;
   localparam int OUT_ID_BITS   = 16;
   localparam int OUT_SLOTS     = 5;
   localparam int OUT_ROWS      = 25;
   localparam int SLOT_BITS     = 3;
   localparam int ROW_BITS      = 5;

   // register reset values
   localparam logic [EXT_BITS-1:0]      EXTENT_RESET = EXT_BITS'(1048576);
   localparam logic [CELL_REG_BITS-1:0] CELLS_RESET  = CELL_REG_BITS'(28);

   // operation codes
   localparam logic [1:0] KIND_QUERY  = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OCCUPIED = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_EXTENT_X = 3'd0,
      CSR_EXTENT_Y = 3'd1,
      CSR_EXTENT_Z = 3'd2,
      CSR_CELLS_X  = 3'd3,
      CSR_CELLS_Y  = 3'd4,
      CSR_CELLS_Z  = 3'd5
   } csr_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_MOD_WAIT,
      ST_FOLD,
      ST_SCALE,
      ST_SCALE_WAIT,
      ST_WINDOW,
      ST_CELL_RD,
      ST_CELL_WB,
      ST_SLOT_RD,
      ST_SLOT_CAP,
      ST_EMIT
   } state_type;

endpackage

@@ design/pcgn_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcgn_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pcgn_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/pcgn_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcgn_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ---------------------------------------------------------------------------
module pcgn_div #(
   parameter int DW = 37,
   parameter int EW = 31
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [EW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [EW-1:0] remainder
);

   localparam int CNT_BITS = $clog2(DW + 1);

   logic [DW-1:0]       num_ff, num_in;
   logic [EW-1:0]       rem_ff, rem_in;
   logic [EW-1:0]       dsr_ff, dsr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [EW:0]         trial;
   logic                fits;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, num_ff[DW-1]};
      fits    = trial >= {1'b0, dsr_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_BITS'(DW);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[DW-2:0], fits};
         rem_in = fits ? EW'(trial - {1'b0, dsr_ff}) : trial[EW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

@@ design/periodic_cell_grid_neighbour_table_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_cell_grid_neighbour_table_unit
// Periodic 3D cell grid, one particle id per cell: insert, remove, query.
// ---------------------------------------------------------------------------
// After reset the block sweeps the cell table clear, one entry per cycle
// (MAX_CELLS_PER_AXIS**3 entries, 32768 at defaults) and takes no request in
// that time. Each request then maps its position to a cell per axis with one
// shared restoring divider: a wrap modulo, then a scaling divide, each with a
// dividend of DW = max(COORD_BITS, 31 + clog2(MAX_CELLS_PER_AXIS+1)) bits
// (37 by default). Insert and remove add a read and a write back of one cell
// and give one transfer. A query reads its window cells one at a time through
// the table's read port, a read state and a capture state per cell, and sends
// one transfer per row, 25 rows by default, each held through any response
// stall. One request is worked on at a time.
// ---------------------------------------------------------------------------
module periodic_cell_grid_neighbour_table_unit #(
   parameter int MAX_CELLS_PER_AXIS = pcgn_pkg::MAX_CELLS_PER_AXIS_DEF,
   parameter int WINDOW_REACH       = pcgn_pkg::WINDOW_REACH_DEF,
   parameter int ID_BITS            = pcgn_pkg::ID_BITS_DEF,
   parameter int COORD_BITS         = pcgn_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic signed [COORD_BITS-1:0]        req_pos_x,
   input  logic signed [COORD_BITS-1:0]        req_pos_y,
   input  logic signed [COORD_BITS-1:0]        req_pos_z,
   input  logic [ID_BITS-1:0]                  req_particle_id,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [pcgn_pkg::OUT_SLOTS-1:0]      rsp_row_mask,
   output logic [pcgn_pkg::OUT_ID_BITS-1:0]    rsp_id_slot0,
   output logic [pcgn_pkg::OUT_ID_BITS-1:0]    rsp_id_slot1,
   output logic [pcgn_pkg::OUT_ID_BITS-1:0]    rsp_id_slot2,
   output logic [pcgn_pkg::OUT_ID_BITS-1:0]    rsp_id_slot3,
   output logic [pcgn_pkg::OUT_ID_BITS-1:0]    rsp_id_slot4,
   output logic                                rsp_last,
   // configuration
   input  logic                                csr_write_en,
   input  logic [pcgn_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [pcgn_pkg::EXT_BITS-1:0]       csr_wdata
);

   localparam int EW     = pcgn_pkg::EXT_BITS;
   localparam int CB     = COORD_BITS;
   localparam int CW     = $clog2(MAX_CELLS_PER_AXIS + 1);
   localparam int IW     = $clog2(MAX_CELLS_PER_AXIS);
   localparam int DW     = (CB > EW + CW) ? CB : EW + CW;
   localparam int DEPTH  = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
   localparam int AW     = $clog2(DEPTH);
   localparam int SPAN   = 2 * WINDOW_REACH + 1;
   localparam int NSLOTS = (SPAN < pcgn_pkg::OUT_SLOTS) ? SPAN : pcgn_pkg::OUT_SLOTS;
   localparam int NROWS  = (SPAN * SPAN < pcgn_pkg::OUT_ROWS) ? SPAN * SPAN
                                                             : pcgn_pkg::OUT_ROWS;
   localparam int SPW    = $clog2(SPAN);
   localparam int SB     = pcgn_pkg::SLOT_BITS;
   localparam int RB     = pcgn_pkg::ROW_BITS;
   localparam int OIB    = pcgn_pkg::OUT_ID_BITS;

   // helpers
   function automatic logic [CW-1:0] eff_cells(input logic [pcgn_pkg::CELL_REG_BITS-1:0] c);
      if (c == '0) begin
         return CW'(1);
      end else if (8'(c) > 8'(MAX_CELLS_PER_AXIS)) begin
         return CW'(MAX_CELLS_PER_AXIS);
      end else begin
         return CW'(c);
      end
   endfunction

   function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] v, input logic [CW-1:0] c);
      if (v == '0) begin
         return IW'(c - 1'b1);
      end else begin
         return v - 1'b1;
      end
   endfunction

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v, input logic [CW-1:0] c);
      if (CW'(v) + CW'(1) == c) begin
         return '0;
      end else begin
         return v + 1'b1;
      end
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] ix, input logic [IW-1:0] iy,
                                             input logic [IW-1:0] iz);
      return AW'((AW'(ix) * AW'(MAX_CELLS_PER_AXIS) + AW'(iy)) * AW'(MAX_CELLS_PER_AXIS)
                 + AW'(iz));
   endfunction

   pcgn_pkg::state_type state_ff, state_in;

   // configuration
   logic [EW-1:0]                         ext_ff [3];
   logic [EW-1:0]                         ext_in [3];
   logic [pcgn_pkg::CELL_REG_BITS-1:0]    cells_ff [3];
   logic [pcgn_pkg::CELL_REG_BITS-1:0]    cells_in [3];

   // request holding and working registers
   logic [1:0]           kind_ff, kind_in;
   logic signed [CB-1:0] pos_ff [3];
   logic signed [CB-1:0] pos_in [3];
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [1:0]           ax_ff, ax_in;
   logic [EW-1:0]        w_ff, w_in;
   logic [IW-1:0]        idx_ff [3];
   logic [IW-1:0]        idx_in [3];
   logic [IW-1:0]        wx_ff, wx_in, wy_ff, wy_in, wz_ff, wz_in;
   logic [IW-1:0]        wy0_ff, wy0_in, wz0_ff, wz0_in;
   logic [SPW-1:0]       dy_ff, dy_in;
   logic [SB-1:0]        slot_ff, slot_in;
   logic [RB-1:0]        row_ff, row_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [1:0]           status_ff, status_in;
   logic [pcgn_pkg::OUT_SLOTS-1:0] mask_ff, mask_in;
   logic [OIB-1:0]       sid_ff [pcgn_pkg::OUT_SLOTS];
   logic [OIB-1:0]       sid_in [pcgn_pkg::OUT_SLOTS];

   // per-axis derived values
   logic [CW-1:0]        cur_c;
   logic [EW-1:0]        cur_e;
   logic signed [CB-1:0] cur_p;
   logic [CB-1:0]        cur_mag;
   logic [CW-1:0]        ceff [3];
   logic [IW-1:0]        wstart [3];

   // divider and table hookup
   logic          div_start;
   logic [DW-1:0] div_dividend;
   logic          div_done;
   logic [DW-1:0] div_quot;
   logic [EW-1:0] div_rem;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [ID_BITS:0] ram_wdata, ram_rdata;
   logic          cell_occ;
   logic          cell_match;
   logic          row_final;

   pcgn_div #(.DW(DW), .EW(EW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cur_e),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   pcgn_ram #(.WIDTH(ID_BITS + 1), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // axis selection and window start coordinates
   always_comb begin
      cur_c   = eff_cells(cells_ff[ax_ff]);
      cur_e   = (ext_ff[ax_ff] == '0) ? EW'(1) : ext_ff[ax_ff];
      cur_p   = pos_ff[ax_ff];
      cur_mag = cur_p[CB-1] ? CB'(~cur_p + 1'b1) : cur_p;
      for (int a = 0; a < 3; a++) begin
         ceff[a]   = eff_cells(cells_ff[a]);
         wstart[a] = idx_ff[a];
         for (int j = 0; j < WINDOW_REACH; j++) begin
            wstart[a] = wrap_dec(wstart[a], ceff[a]);
         end
      end
   end

   assign cell_occ   = ram_rdata[ID_BITS];
   assign cell_match = cell_occ && (ram_rdata[ID_BITS-1:0] == id_ff);
   assign row_final  = (kind_ff != pcgn_pkg::KIND_QUERY) || (row_ff == RB'(NROWS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcgn_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = pcgn_pkg::ST_IDLE;
            end
         end
         pcgn_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pcgn_pkg::ST_MOD;
            end
         end
         pcgn_pkg::ST_MOD:      state_in = pcgn_pkg::ST_MOD_WAIT;
         pcgn_pkg::ST_MOD_WAIT: begin
            if (div_done) begin
               state_in = pcgn_pkg::ST_FOLD;
            end
         end
         pcgn_pkg::ST_FOLD:     state_in = pcgn_pkg::ST_SCALE;
         pcgn_pkg::ST_SCALE:    state_in = pcgn_pkg::ST_SCALE_WAIT;
         pcgn_pkg::ST_SCALE_WAIT: begin
            if (div_done) begin
               state_in = (ax_ff == 2'd2) ? pcgn_pkg::ST_WINDOW : pcgn_pkg::ST_MOD;
            end
         end
         pcgn_pkg::ST_WINDOW: begin
            if (kind_ff == pcgn_pkg::KIND_QUERY) begin
               state_in = pcgn_pkg::ST_SLOT_RD;
            end else if (kind_ff == pcgn_pkg::KIND_INSERT
                         || kind_ff == pcgn_pkg::KIND_REMOVE) begin
               state_in = pcgn_pkg::ST_CELL_RD;
            end else begin
               state_in = pcgn_pkg::ST_IDLE;
            end
         end
         pcgn_pkg::ST_CELL_RD:  state_in = pcgn_pkg::ST_CELL_WB;
         pcgn_pkg::ST_CELL_WB:  state_in = pcgn_pkg::ST_EMIT;
         pcgn_pkg::ST_SLOT_RD:  state_in = pcgn_pkg::ST_SLOT_CAP;
         pcgn_pkg::ST_SLOT_CAP: begin
            state_in = (slot_ff == SB'(NSLOTS - 1)) ? pcgn_pkg::ST_EMIT
                                                   : pcgn_pkg::ST_SLOT_RD;
         end
         pcgn_pkg::ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = row_final ? pcgn_pkg::ST_IDLE : pcgn_pkg::ST_SLOT_RD;
            end
         end
         default: state_in = pcgn_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall    = (state_ff != pcgn_pkg::ST_IDLE);
      rsp_valid    = (state_ff == pcgn_pkg::ST_EMIT);
      div_start    = (state_ff == pcgn_pkg::ST_MOD) || (state_ff == pcgn_pkg::ST_SCALE);
      div_dividend = (state_ff == pcgn_pkg::ST_SCALE) ? DW'(w_ff) * DW'(cur_c)
                                                       : DW'(cur_mag);
      ram_raddr    = (state_ff == pcgn_pkg::ST_CELL_RD) ? addr_of(idx_ff[0], idx_ff[1],
                                                                  idx_ff[2])
                                                       : addr_of(wx_ff, wy_ff, wz_ff);
      ram_we       = 1'b0;
      ram_waddr    = addr_of(idx_ff[0], idx_ff[1], idx_ff[2]);
      ram_wdata    = '0;
      case (state_ff)
         pcgn_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
         end
         pcgn_pkg::ST_CELL_WB: begin
            if (kind_ff == pcgn_pkg::KIND_INSERT) begin
               ram_we    = !cell_occ;
               ram_wdata = {1'b1, id_ff};
            end else begin
               ram_we    = cell_match;
            end
         end
         default: ram_we = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      id_in     = id_ff;
      ax_in     = ax_ff;
      w_in      = w_ff;
      idx_in    = idx_ff;
      wx_in     = wx_ff;
      wy_in     = wy_ff;
      wz_in     = wz_ff;
      wy0_in    = wy0_ff;
      wz0_in    = wz0_ff;
      dy_in     = dy_ff;
      slot_in   = slot_ff;
      row_in    = row_ff;
      clr_in    = clr_ff;
      status_in = status_ff;
      mask_in   = mask_ff;
      sid_in    = sid_ff;
      ext_in    = ext_ff;
      cells_in  = cells_ff;

      // register writes
      if (csr_write_en) begin
         case (csr_index)
            pcgn_pkg::CSR_EXTENT_X: ext_in[0]   = csr_wdata;
            pcgn_pkg::CSR_EXTENT_Y: ext_in[1]   = csr_wdata;
            pcgn_pkg::CSR_EXTENT_Z: ext_in[2]   = csr_wdata;
            pcgn_pkg::CSR_CELLS_X:  cells_in[0] = csr_wdata[pcgn_pkg::CELL_REG_BITS-1:0];
            pcgn_pkg::CSR_CELLS_Y:  cells_in[1] = csr_wdata[pcgn_pkg::CELL_REG_BITS-1:0];
            pcgn_pkg::CSR_CELLS_Z:  cells_in[2] = csr_wdata[pcgn_pkg::CELL_REG_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         pcgn_pkg::ST_CLEAR: clr_in = clr_ff + 1'b1;
         pcgn_pkg::ST_IDLE: begin
            kind_in   = req_kind;
            pos_in[0] = req_pos_x;
            pos_in[1] = req_pos_y;
            pos_in[2] = req_pos_z;
            id_in     = req_particle_id;
            ax_in     = 2'd0;
         end
         // true modulo: a negative value with nonzero remainder folds to e - r
         pcgn_pkg::ST_FOLD: begin
            w_in = (cur_p[CB-1] && div_rem != '0) ? cur_e - div_rem : div_rem;
         end
         pcgn_pkg::ST_SCALE_WAIT: begin
            if (div_done) begin
               idx_in[ax_ff] = div_quot[IW-1:0];
               ax_in         = ax_ff + 1'b1;
            end
         end
         pcgn_pkg::ST_WINDOW: begin
            wx_in     = wstart[0];
            wy_in     = wstart[1];
            wy0_in    = wstart[1];
            wz_in     = wstart[2];
            wz0_in    = wstart[2];
            dy_in     = '0;
            slot_in   = '0;
            row_in    = '0;
            status_in = pcgn_pkg::STATUS_OK;
            mask_in   = '0;
            for (int k = 0; k < pcgn_pkg::OUT_SLOTS; k++) begin
               sid_in[k] = '0;
            end
         end
         pcgn_pkg::ST_CELL_WB: begin
            if (kind_ff == pcgn_pkg::KIND_INSERT) begin
               status_in = cell_occ ? pcgn_pkg::STATUS_OCCUPIED : pcgn_pkg::STATUS_OK;
            end else begin
               status_in = cell_match ? pcgn_pkg::STATUS_OK : pcgn_pkg::STATUS_MISMATCH;
            end
         end
         // capture one window cell and step along z
         pcgn_pkg::ST_SLOT_CAP: begin
            mask_in[slot_ff] = cell_occ;
            sid_in[slot_ff]  = cell_occ ? OIB'(ram_rdata[ID_BITS-1:0]) : '0;
            wz_in            = wrap_inc(wz_ff, ceff[2]);
            slot_in          = slot_ff + 1'b1;
         end
         // row handed over: move to the next (dx, dy) pair
         pcgn_pkg::ST_EMIT: begin
            if (!rsp_stall && !row_final) begin
               row_in  = row_ff + 1'b1;
               slot_in = '0;
               wz_in   = wz0_ff;
               mask_in = '0;
               for (int k = 0; k < pcgn_pkg::OUT_SLOTS; k++) begin
                  sid_in[k] = '0;
               end
               if (dy_ff == SPW'(SPAN - 1)) begin
                  dy_in = '0;
                  wy_in = wy0_ff;
                  wx_in = wrap_inc(wx_ff, ceff[0]);
               end else begin
                  dy_in = dy_ff + 1'b1;
                  wy_in = wrap_inc(wy_ff, ceff[1]);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcgn_pkg::ST_CLEAR;
         clr_ff   <= '0;
         ax_ff    <= '0;
         for (int a = 0; a < 3; a++) begin
            ext_ff[a]   <= pcgn_pkg::EXTENT_RESET;
            cells_ff[a] <= pcgn_pkg::CELLS_RESET;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ax_ff    <= ax_in;
         ext_ff   <= ext_in;
         cells_ff <= cells_in;
      end
      kind_ff   <= kind_in;
      pos_ff    <= pos_in;
      id_ff     <= id_in;
      w_ff      <= w_in;
      idx_ff    <= idx_in;
      wx_ff     <= wx_in;
      wy_ff     <= wy_in;
      wz_ff     <= wz_in;
      wy0_ff    <= wy0_in;
      wz0_ff    <= wz0_in;
      dy_ff     <= dy_in;
      slot_ff   <= slot_in;
      row_ff    <= row_in;
      status_ff <= status_in;
      mask_ff   <= mask_in;
      sid_ff    <= sid_in;
   end

   assign rsp_status   = status_ff;
   assign rsp_row_mask = mask_ff;
   assign rsp_id_slot0 = sid_ff[0];
   assign rsp_id_slot1 = sid_ff[1];
   assign rsp_id_slot2 = sid_ff[2];
   assign rsp_id_slot3 = sid_ff[3];
   assign rsp_id_slot4 = sid_ff[4];
   assign rsp_last     = row_final;

endmodule

@@ design/pcgn_chk.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcgn_chk
// Port level checks of the neighbour table unit, bound to the top level.
// ---------------------------------------------------------------------------
module pcgn_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [1:0]                     rsp_status,
   input logic [pcgn_pkg::OUT_SLOTS-1:0] rsp_row_mask,
   input logic                           rsp_last
);

   // no new request while a result is on offer
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   // an error is a single, empty transfer
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != pcgn_pkg::STATUS_OK) |-> (rsp_last && rsp_row_mask == '0))
      else $error("error result is not a lone empty row");

   // more rows follow a non-final transfer, so no request in between
   a_rows_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> req_stall)
      else $error("request window opened inside a query");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_last) && $stable(rsp_row_mask)))
      else $error("stalled result changed");

   // nothing offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind periodic_cell_grid_neighbour_table_unit pcgn_chk u_pcgn_chk (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_row_mask (rsp_row_mask),
   .rsp_last     (rsp_last)
);
